// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the spin update unit modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that holds at every clock edge out of reset
`define ISU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that forces a consequence in the next cycle
`define ISU_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define ISU_ASSERT(lbl, prop, msg)
`define ISU_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ----- hw/rtl/isu_pkg.sv -----
// shared types and constants of the ising spin update unit
`default_nettype none

package isu_pkg;

    // field widths
    localparam int SITE_W     = 10;
    localparam int RND_W      = 32;
    localparam int THR_W      = 32;
    localparam int CNT_W      = 32;
    localparam int MAG_W      = 12;
    localparam int LEN_W      = 11;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // ring length minimum and reset value
    localparam int MIN_RING = 3;
    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    // signed unit steps for the ring sums
    localparam logic signed [MAG_W-1:0] PLUS_ONE  = 12'sd1;
    localparam logic signed [MAG_W-1:0] MINUS_ONE = -12'sd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GIBBS_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_A      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_B      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_C      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEATBATH_A  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HEATBATH_B  = 3'd6;

    // command opcodes
    typedef enum logic [OP_W-1:0] {
        OP_TRIAL   = 2'd0,
        OP_LOAD    = 2'd1,
        OP_MEASURE = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    // spin memory read address source
    typedef enum logic [1:0] {
        RD_LEFT  = 2'd0,
        RD_RIGHT = 2'd1,
        RD_SITE  = 2'd2,
        RD_SCAN  = 2'd3
    } rd_sel_t;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        rd_sel_t rd_sel;
        logic    left_en;
        logic    right_en;
        logic    scan_en;
        logic    finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic site_ok;
        logic scan_last;
    } status_t;

    // saturating counter step
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/isu_ctrl.sv -----
// sequencing state machine of the spin update unit
`default_nettype none
`include "assert_macros.svh"

module isu_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  isu_pkg::status_t       status,
    output isu_pkg::cmd_t          cmd
);
    import isu_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RIGHT  = 7'b0000010,
        S_CUR    = 7'b0000100,
        S_TRIAL  = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_CLOSE  = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   slot_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.rd_sel   = RD_SITE;
        cmd.left_en  = 1'b0;
        cmd.right_en = 1'b0;
        cmd.scan_en  = 1'b0;
        cmd.finish   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    if (status.op == OP_TRIAL && status.site_ok)
                        state_next = S_RIGHT;
                    else if (status.op == OP_MEASURE)
                        state_next = S_SCAN;
                    else
                        state_next = S_FINISH;
                end
            end
            S_RIGHT:
            begin
                cmd.rd_sel  = RD_RIGHT;
                cmd.left_en = 1'b1;
                state_next  = S_CUR;
            end
            S_CUR:
            begin
                cmd.rd_sel   = RD_SITE;
                cmd.right_en = 1'b1;
                state_next   = S_TRIAL;
            end
            S_TRIAL:
            begin
                cmd.rd_sel = RD_SITE;
                if (slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.rd_sel  = RD_SCAN;
                cmd.scan_en = 1'b1;
                if (status.scan_last)
                    state_next = S_CLOSE;
            end
            S_CLOSE, S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result word valid flag
    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ISU_ASSERT(a_no_overwrite, !(cmd.finish && out_valid_reg && out_stall), "result word overwritten while stalled")
    `ISU_ASSERT(a_valid_from_finish, $rose(out_valid_reg) |-> $past(cmd.finish), "result word raised without a finished command")

endmodule

`default_nettype wire

// ----- hw/rtl/isu_datapath.sv -----
// spin memory, thresholds, counters and ring sums of the spin update unit
`default_nettype none
`include "assert_macros.svh"

module isu_datapath #(
    parameter int MAX_SPINS = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_write_en,
    input  wire logic [isu_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [isu_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire logic [isu_pkg::OP_W-1:0]               opcode,
    input  wire logic [isu_pkg::SITE_W-1:0]             site,
    input  wire logic [isu_pkg::RND_W-1:0]              random_value,
    input  wire logic                                   spin_value,
    input  isu_pkg::cmd_t                               cmd,
    output isu_pkg::status_t                            status,
    output logic                                        new_spin,
    output logic                                        flip_accepted,
    output logic signed [isu_pkg::MAG_W-1:0]            magnetization,
    output logic signed [isu_pkg::MAG_W-1:0]            bond_sum,
    output logic [isu_pkg::CNT_W-1:0]                   attempted_count,
    output logic [isu_pkg::CNT_W-1:0]                   accepted_count
);
    import isu_pkg::*;

    localparam int AW = $clog2(MAX_SPINS);
    localparam int NW = ($clog2(MAX_SPINS + 1) > LEN_W) ? $clog2(MAX_SPINS + 1) : LEN_W;

    // configuration registers
    logic             gibbs_mode_reg;
    logic [LEN_W-1:0] ring_len_reg;
    logic [63:0]      flip_a_reg;
    logic [63:0]      flip_b_reg;
    logic [63:0]      flip_c_reg;
    logic [63:0]      hb_a_reg;
    logic [THR_W-1:0] hb_b_reg;

    // captured command word
    op_t              op_reg;
    logic             site_ok_reg;
    logic [NW-1:0]    site_reg;
    logic [RND_W-1:0] rnd_reg;
    logic             load_spin_reg;

    // trial and scan state
    logic                    left_reg;
    logic                    right_reg;
    logic [NW-1:0]           scan_cnt_reg;
    logic                    first_reg;
    logic                    prev_reg;
    logic signed [MAG_W-1:0] mag_acc_reg;
    logic signed [MAG_W-1:0] bond_acc_reg;

    // counters
    logic [CNT_W-1:0] trials_cnt_reg, trials_cnt_next;
    logic [CNT_W-1:0] accepts_cnt_reg, accepts_cnt_next;

    // result word
    logic                    spin_out_reg, spin_out_next;
    logic                    flip_out_reg, flip_out_next;
    logic signed [MAG_W-1:0] mag_out_reg, mag_out_next;
    logic signed [MAG_W-1:0] bond_out_reg, bond_out_next;

    // spin memory
    logic          spin_mem [MAX_SPINS];
    logic          rdata_reg;
    logic [AW-1:0] raddr;
    logic          mem_we;

    logic [NW-1:0]    len_ext;
    logic [NW-1:0]    ring_n;
    logic [NW-1:0]    in_site_ext;
    logic [NW-1:0]    in_left;
    logic [NW-1:0]    site_right;
    logic [1:0]       nbr_sum;
    logic [2:0]       flip_idx;
    logic [THR_W-1:0] flip_thr;
    logic [THR_W-1:0] gibbs_thr;
    logic             pass_metro;
    logic             pass_gibbs;
    logic             trial_spin;
    logic             trial_flip;

    // effective ring length, clamped to the supported range
    always_comb
    begin
        len_ext = NW'(ring_len_reg);
        if (len_ext < NW'(MIN_RING))
            ring_n = NW'(MIN_RING);
        else if (len_ext > NW'(MAX_SPINS))
            ring_n = NW'(MAX_SPINS);
        else
            ring_n = len_ext;
    end

    // periodic neighbors
    assign in_site_ext = NW'(site);
    assign in_left     = (in_site_ext == '0) ? ring_n - 1'b1 : in_site_ext - 1'b1;
    assign site_right  = (site_reg + 1'b1 == ring_n) ? '0 : site_reg + 1'b1;

    assign status.op        = op_t'(opcode);
    assign status.site_ok   = (in_site_ext < ring_n);
    assign status.scan_last = (scan_cnt_reg == ring_n);

    // read address select
    always_comb
    begin
        if (cmd.capture)
            raddr = (op_t'(opcode) == OP_MEASURE) ? '0 : in_left[AW-1:0];
        else
        begin
            case (cmd.rd_sel)
                RD_LEFT:  raddr = in_left[AW-1:0];
                RD_RIGHT: raddr = site_right[AW-1:0];
                RD_SITE:  raddr = site_reg[AW-1:0];
                RD_SCAN:  raddr = scan_cnt_reg[AW-1:0];
                default:  raddr = site_reg[AW-1:0];
            endcase
        end
    end

    // threshold select and acceptance tests
    always_comb
    begin
        nbr_sum  = {1'b0, left_reg} + {1'b0, right_reg};
        flip_idx = (rdata_reg ? 3'd0 : 3'd3) + {1'b0, nbr_sum};
        case (flip_idx)
            3'd0:    flip_thr = flip_a_reg[31:0];
            3'd1:    flip_thr = flip_a_reg[63:32];
            3'd2:    flip_thr = flip_b_reg[31:0];
            3'd3:    flip_thr = flip_b_reg[63:32];
            3'd4:    flip_thr = flip_c_reg[31:0];
            3'd5:    flip_thr = flip_c_reg[63:32];
            default: flip_thr = '0;
        endcase
        case (nbr_sum)
            2'd0:    gibbs_thr = hb_a_reg[31:0];
            2'd1:    gibbs_thr = hb_a_reg[63:32];
            default: gibbs_thr = hb_b_reg;
        endcase
        pass_metro = (rnd_reg <= flip_thr);
        pass_gibbs = (rnd_reg <= gibbs_thr);
        trial_spin = gibbs_mode_reg ? pass_gibbs : (rdata_reg ^ pass_metro);
        trial_flip = !gibbs_mode_reg && pass_metro;
    end

    // result word and counter updates
    always_comb
    begin
        spin_out_next    = 1'b0;
        flip_out_next    = 1'b0;
        mag_out_next     = '0;
        bond_out_next    = '0;
        trials_cnt_next  = trials_cnt_reg;
        accepts_cnt_next = accepts_cnt_reg;
        mem_we           = 1'b0;
        case (op_reg)
            OP_TRIAL:
            begin
                if (site_ok_reg)
                begin
                    spin_out_next = trial_spin;
                    flip_out_next = trial_flip;
                    mem_we        = cmd.finish;
                    if (!gibbs_mode_reg)
                        trials_cnt_next = sat_inc(trials_cnt_reg);
                    if (trial_flip)
                        accepts_cnt_next = sat_inc(accepts_cnt_reg);
                end
            end
            OP_LOAD:
            begin
                if (site_ok_reg)
                begin
                    spin_out_next = load_spin_reg;
                    mem_we        = cmd.finish;
                end
            end
            OP_MEASURE:
            begin
                mag_out_next  = mag_acc_reg;
                bond_out_next = bond_acc_reg + ((prev_reg == first_reg) ? PLUS_ONE : MINUS_ONE);
            end
            OP_CLEAR:
            begin
                trials_cnt_next  = '0;
                accepts_cnt_next = '0;
            end
            default:
            begin
                spin_out_next = 1'b0;
            end
        endcase
    end

    // spin memory ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            spin_mem[site_reg[AW-1:0]] <= spin_out_next;
        rdata_reg <= spin_mem[raddr];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gibbs_mode_reg <= 1'b0;
            ring_len_reg   <= LEN_RESET;
            flip_a_reg     <= '0;
            flip_b_reg     <= '0;
            flip_c_reg     <= '0;
            hb_a_reg       <= '0;
            hb_b_reg       <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_GIBBS_MODE:  gibbs_mode_reg <= cfg_data[0];
                CFG_RING_LENGTH: ring_len_reg   <= cfg_data[LEN_W-1:0];
                CFG_FLIP_A:      flip_a_reg     <= cfg_data;
                CFG_FLIP_B:      flip_b_reg     <= cfg_data;
                CFG_FLIP_C:      flip_c_reg     <= cfg_data;
                CFG_HEATBATH_A:  hb_a_reg       <= cfg_data;
                CFG_HEATBATH_B:  hb_b_reg       <= cfg_data[THR_W-1:0];
                default:         gibbs_mode_reg <= gibbs_mode_reg;
            endcase
        end
    end

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trials_cnt_reg  <= '0;
            accepts_cnt_reg <= '0;
        end
        else if (cmd.finish)
        begin
            trials_cnt_reg  <= trials_cnt_next;
            accepts_cnt_reg <= accepts_cnt_next;
        end
    end

    // command capture, neighbor capture and ring scan
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= op_t'(opcode);
            site_ok_reg   <= status.site_ok;
            site_reg      <= in_site_ext;
            rnd_reg       <= random_value;
            load_spin_reg <= spin_value;
            scan_cnt_reg  <= NW'(1);
            mag_acc_reg   <= '0;
            bond_acc_reg  <= '0;
        end
        else if (cmd.scan_en)
        begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
            mag_acc_reg  <= mag_acc_reg + (rdata_reg ? PLUS_ONE : MINUS_ONE);
            prev_reg     <= rdata_reg;
            if (scan_cnt_reg == NW'(1))
                first_reg <= rdata_reg;
            else
                bond_acc_reg <= bond_acc_reg + ((prev_reg == rdata_reg) ? PLUS_ONE : MINUS_ONE);
        end
        if (cmd.left_en)
            left_reg <= rdata_reg;
        if (cmd.right_en)
            right_reg <= rdata_reg;
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            spin_out_reg <= spin_out_next;
            flip_out_reg <= flip_out_next;
            mag_out_reg  <= mag_out_next;
            bond_out_reg <= bond_out_next;
        end
    end

    assign new_spin        = spin_out_reg;
    assign flip_accepted   = flip_out_reg;
    assign magnetization   = mag_out_reg;
    assign bond_sum        = bond_out_reg;
    assign attempted_count = trials_cnt_reg;
    assign accepted_count  = accepts_cnt_reg;

    `ISU_ASSERT(a_accepts_le_trials, accepts_cnt_reg <= trials_cnt_reg, "accepted count above attempted count")
    `ISU_ASSERT_NEXT(a_clear_zeroes, cmd.finish && op_reg == OP_CLEAR, trials_cnt_reg == '0 && accepts_cnt_reg == '0, "clear left a counter nonzero")

endmodule

`default_nettype wire

// ----- hw/rtl/ising_1d_spin_update_unit.sv -----
// top level of the 1d ising spin update unit
// result word registered by the final state once the output slot is free: trial goes
// via right, cur and trial, load, clear and bad-site trials via finish, measure via scan
// and close; one command word in flight, the next is accepted once back in idle
// the sequence is set by the single read port of the spin memory: one spin read per cycle
// reset clears control state, counters and config registers; spin memory stays unwritten
`default_nettype none

module ising_1d_spin_update_unit #(
    parameter int MAX_SPINS = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_write_en,
    input  wire logic [isu_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [isu_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [isu_pkg::OP_W-1:0]               opcode,
    input  wire logic [isu_pkg::SITE_W-1:0]             site,
    input  wire logic [isu_pkg::RND_W-1:0]              random_value,
    input  wire logic                                   spin_value,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        new_spin,
    output logic                                        flip_accepted,
    output logic signed [isu_pkg::MAG_W-1:0]            magnetization,
    output logic signed [isu_pkg::MAG_W-1:0]            bond_sum,
    output logic [isu_pkg::CNT_W-1:0]                   attempted_count,
    output logic [isu_pkg::CNT_W-1:0]                   accepted_count
);
    import isu_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    isu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // spin memory and arithmetic
    isu_datapath #(
        .MAX_SPINS (MAX_SPINS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .site            (site),
        .random_value    (random_value),
        .spin_value      (spin_value),
        .cmd             (cmd),
        .status          (status),
        .new_spin        (new_spin),
        .flip_accepted   (flip_accepted),
        .magnetization   (magnetization),
        .bond_sum        (bond_sum),
        .attempted_count (attempted_count),
        .accepted_count  (accepted_count)
    );

endmodule

`default_nettype wire
